@@ hw/rtl/block_orientation_histogram_assert.svh @@
// Assertion macros for the block orientation histogram.
`ifndef BLOCK_ORIENTATION_HISTOGRAM_ASSERT_SVH
`define BLOCK_ORIENTATION_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BOH_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block_orientation_histogram: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BOH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block_orientation_histogram: check failed");

`endif

@@ hw/rtl/boh_pkg.sv @@
// Shared types and constants for the block orientation histogram.
package boh_pkg;

    localparam int NUM_BINS   = 8;
    localparam int BIN_W      = 3;
    localparam int GRAD_W     = 13;
    localparam int MAG_W      = 26;
    localparam int THR_W      = 25;
    localparam int BP_W       = 14;
    localparam int PROD_W     = 31;
    localparam int TAN_W      = 18;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_PIXELS = 2'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET    = 25'd0;
    localparam logic [BP_W-1:0]  BLOCK_PIXELS_RESET = 14'd4900;

    // tan(pi/8) and tan(3pi/8) in unsigned Q16
    localparam logic [TAN_W-1:0] TAN_1_8 = 18'd27146;
    localparam logic [TAN_W-1:0] TAN_3_8 = 18'd158218;

    localparam logic [BIN_W-1:0] BIN_VERTICAL = 3'd4;

    typedef struct packed {
        logic             upd;
        logic             bin_en;
        logic [BIN_W-1:0] bin;
        logic             clear;
    } acc_ctl_t;

    typedef struct packed {
        logic             vote;
        logic [BIN_W-1:0] bin;
        logic             clear;
    } vote_ctl_t;

endpackage

@@ hw/rtl/boh_classify.sv @@
// Per-pixel squared magnitude and orientation sector.
module boh_classify (
    input  logic signed [boh_pkg::GRAD_W-1:0] grad_x,
    input  logic signed [boh_pkg::GRAD_W-1:0] grad_y,
    output logic        [boh_pkg::MAG_W-1:0]  mag_sq,
    output logic                              bin_en,
    output logic        [boh_pkg::BIN_W-1:0]  bin
);

    logic signed [boh_pkg::MAG_W-1:0]  sx;
    logic signed [boh_pkg::MAG_W-1:0]  sy;
    logic signed [boh_pkg::GRAD_W:0]   fx;
    logic signed [boh_pkg::GRAD_W:0]   fy;
    logic signed [boh_pkg::GRAD_W:0]   fx_abs;
    logic        [boh_pkg::GRAD_W-1:0] ax;
    logic        [boh_pkg::GRAD_W-1:0] ay;
    logic        [boh_pkg::PROD_W-1:0] yy;
    logic        [boh_pkg::PROD_W-1:0] p1;
    logic        [boh_pkg::PROD_W-1:0] p2;
    logic        [boh_pkg::PROD_W-1:0] p3;

    always_comb
    begin
        sx     = grad_x * grad_x;
        sy     = grad_y * grad_y;
        mag_sq = $unsigned(sx) + $unsigned(sy);

        // fold the angle into [0, pi)
        if (grad_y[boh_pkg::GRAD_W-1])
        begin
            fx = -((boh_pkg::GRAD_W+1)'(grad_x));
            fy = -((boh_pkg::GRAD_W+1)'(grad_y));
        end
        else
        begin
            fx = (boh_pkg::GRAD_W+1)'(grad_x);
            fy = (boh_pkg::GRAD_W+1)'(grad_y);
        end
        fx_abs = fx[boh_pkg::GRAD_W] ? -fx : fx;
        ax     = fx_abs[boh_pkg::GRAD_W-1:0];
        ay     = fy[boh_pkg::GRAD_W-1:0];

        yy = boh_pkg::PROD_W'({ay, boh_pkg::FRAC_W'(0)});
        p1 = boh_pkg::PROD_W'(ax) * boh_pkg::PROD_W'(boh_pkg::TAN_1_8);
        p2 = boh_pkg::PROD_W'({ax, boh_pkg::FRAC_W'(0)});
        p3 = boh_pkg::PROD_W'(ax) * boh_pkg::PROD_W'(boh_pkg::TAN_3_8);

        bin_en = 1'b1;
        bin    = boh_pkg::BIN_W'(0);
        priority if (fy == '0)
        begin
            // angle of exactly pi is counted but not binned
            bin_en = !fx[boh_pkg::GRAD_W];
        end
        else if (fx == '0)
        begin
            bin = boh_pkg::BIN_VERTICAL;
        end
        else if (!fx[boh_pkg::GRAD_W])
        begin
            priority if (yy < p1)
                bin = boh_pkg::BIN_W'(0);
            else if (yy < p2)
                bin = boh_pkg::BIN_W'(1);
            else if (yy < p3)
                bin = boh_pkg::BIN_W'(2);
            else
                bin = boh_pkg::BIN_W'(3);
        end
        else
        begin
            priority if (yy > p3)
                bin = boh_pkg::BIN_W'(4);
            else if (yy > p2)
                bin = boh_pkg::BIN_W'(5);
            else if (yy > p1)
                bin = boh_pkg::BIN_W'(6);
            else
                bin = boh_pkg::BIN_W'(7);
        end
    end

endmodule

@@ hw/rtl/boh_argmax8.sv @@
// Index of the largest of eight values, lowest index on ties.
module boh_argmax8 #(
    parameter int WIDTH = 14
) (
    input  logic [WIDTH-1:0]          vals [boh_pkg::NUM_BINS],
    output logic [boh_pkg::BIN_W-1:0] idx
);

    logic [WIDTH-1:0]          v1 [4];
    logic [boh_pkg::BIN_W-1:0] i1 [4];
    logic [WIDTH-1:0]          v2 [2];
    logic [boh_pkg::BIN_W-1:0] i2 [2];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (vals[2*k+1] > vals[2*k])
            begin
                v1[k] = vals[2*k+1];
                i1[k] = boh_pkg::BIN_W'(2*k+1);
            end
            else
            begin
                v1[k] = vals[2*k];
                i1[k] = boh_pkg::BIN_W'(2*k);
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            if (v1[2*k+1] > v1[2*k])
            begin
                v2[k] = v1[2*k+1];
                i2[k] = i1[2*k+1];
            end
            else
            begin
                v2[k] = v1[2*k];
                i2[k] = i1[2*k];
            end
        end
        idx = (v2[1] > v2[0]) ? i2[1] : i2[0];
    end

endmodule

@@ hw/rtl/boh_bin_accum.sv @@
// Per-block orientation bins and strong pixel count, saturating.
module boh_bin_accum #(
    parameter int CNT_W   = 14,
    parameter int MAX_CNT = 8192
) (
    input  logic              clk,
    input  logic              rst_n,
    input  boh_pkg::acc_ctl_t ctl,
    output logic [CNT_W-1:0]  bins_next [boh_pkg::NUM_BINS],
    output logic [CNT_W-1:0]  cnt_next
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_CNT);

    logic [CNT_W-1:0] bins_reg [boh_pkg::NUM_BINS];
    logic [CNT_W-1:0] cnt_reg;

    always_comb
    begin
        for (int b = 0; b < boh_pkg::NUM_BINS; b++)
        begin
            bins_next[b] = bins_reg[b];
            if (ctl.upd && ctl.bin_en && ctl.bin == boh_pkg::BIN_W'(b) && bins_reg[b] < CAP)
                bins_next[b] = bins_reg[b] + 1'b1;
        end
        cnt_next = cnt_reg;
        if (ctl.upd && cnt_reg < CAP)
            cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < boh_pkg::NUM_BINS; b++)
                bins_reg[b] <= '0;
            cnt_reg <= '0;
        end
        else if (ctl.clear)
        begin
            for (int b = 0; b < boh_pkg::NUM_BINS; b++)
                bins_reg[b] <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            bins_reg <= bins_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/boh_vote_tally.sv @@
// Per-frame direction votes, saturating, cleared at frame end.
module boh_vote_tally #(
    parameter int VOTE_W    = 11,
    parameter int MAX_VOTES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  boh_pkg::vote_ctl_t ctl,
    output logic [VOTE_W-1:0]  tally_next [boh_pkg::NUM_BINS]
);

    localparam logic [VOTE_W-1:0] CAP = VOTE_W'(MAX_VOTES);

    logic [VOTE_W-1:0] tally_reg [boh_pkg::NUM_BINS];

    always_comb
    begin
        for (int b = 0; b < boh_pkg::NUM_BINS; b++)
        begin
            tally_next[b] = tally_reg[b];
            if (ctl.vote && ctl.bin == boh_pkg::BIN_W'(b) && tally_reg[b] < CAP)
                tally_next[b] = tally_reg[b] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < boh_pkg::NUM_BINS; b++)
                tally_reg[b] <= '0;
        end
        else if (ctl.clear)
        begin
            for (int b = 0; b < boh_pkg::NUM_BINS; b++)
                tally_reg[b] <= '0;
        end
        else
        begin
            tally_reg <= tally_next;
        end
    end

endmodule

@@ hw/rtl/block_orientation_histogram.sv @@
// Top level: pixel gradient stream in, per-block orientation result out.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------------
//  in      | in_valid / in_stall        | grad_x grad_y last_in_block last_in_frame
//  out     | out_valid / out_stall      | block_direction neighbor_sum valid_count
//          |                            | block_qualified frame_direction frame_done
//  cfg     | cfg_valid / cfg_ready      | cfg_index cfg_data
//
// One pixel per cycle sustained while in_stall is low. A result reaches the output
// register after the transfer of the pixel that ends its block, through the input,
// classify, histogram snapshot, peak, vote and output stages.
// Reset clears all bins, the strong count, the votes and the stage valid bits.
// Only block-end pixels travel past the histogram stage, so pixels keep flowing
// while a result waits; in_stall rises only when a block end meets a full path.
module block_orientation_histogram #(
    parameter int MAX_BLOCK_PIXELS = 8192,
    parameter int MAX_BLOCKS       = 1024
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [boh_pkg::GRAD_W-1:0]       grad_x,
    input  logic signed [boh_pkg::GRAD_W-1:0]       grad_y,
    input  logic                                    last_in_block,
    input  logic                                    last_in_frame,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [boh_pkg::BIN_W-1:0]               block_direction,
    output logic [$clog2(MAX_BLOCK_PIXELS+1)-1:0]   neighbor_sum,
    output logic [$clog2(MAX_BLOCK_PIXELS+1)-1:0]   valid_count,
    output logic                                    block_qualified,
    output logic [boh_pkg::BIN_W-1:0]               frame_direction,
    output logic                                    frame_done,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [boh_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [boh_pkg::CFG_DATA_W-1:0]          cfg_data
);

    `include "block_orientation_histogram_assert.svh"

    localparam int CNT_W  = $clog2(MAX_BLOCK_PIXELS + 1);
    localparam int VOTE_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W  = CNT_W + 2;
    localparam int QW     = (CNT_W + 5 > boh_pkg::BP_W) ? CNT_W + 5 : boh_pkg::BP_W;
    localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(MAX_BLOCK_PIXELS);

    // configuration
    logic [boh_pkg::THR_W-1:0] thr_reg;
    logic [boh_pkg::BP_W-1:0]  bp_reg;

    // stage handshake
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;
    logic adv1, adv3;

    // stage 0: input register
    logic                              v0_reg;
    logic signed [boh_pkg::GRAD_W-1:0] gx0_reg;
    logic signed [boh_pkg::GRAD_W-1:0] gy0_reg;
    logic                              lb0_reg;
    logic                              lf0_reg;

    // stage 1: classified pixel
    logic [boh_pkg::MAG_W-1:0] mag_next;
    logic                      bin_en_next;
    logic [boh_pkg::BIN_W-1:0] bin_next;
    logic                      v1_reg;
    logic [boh_pkg::MAG_W-1:0] mag1_reg;
    logic                      bin_en1_reg;
    logic [boh_pkg::BIN_W-1:0] bin1_reg;
    logic                      lb1_reg;
    logic                      lf1_reg;

    // stage 2: histogram snapshot at block end
    boh_pkg::acc_ctl_t acc_ctl;
    logic [CNT_W-1:0]  bins_next [boh_pkg::NUM_BINS];
    logic [CNT_W-1:0]  cnt_next;
    logic              v2_reg;
    logic [CNT_W-1:0]  bins2_reg [boh_pkg::NUM_BINS];
    logic [CNT_W-1:0]  cnt2_reg;
    logic              lf2_reg;

    // stage 3: peak and neighbor sum
    logic [boh_pkg::BIN_W-1:0] peak_next;
    logic [SUM_W-1:0]          nsum_wide;
    logic [CNT_W-1:0]          nsum_next;
    logic                      v3_reg;
    logic [boh_pkg::BIN_W-1:0] peak3_reg;
    logic [CNT_W-1:0]          nsum3_reg;
    logic [CNT_W-1:0]          cnt3_reg;
    logic                      lf3_reg;

    // stage 4: qualification and vote
    logic [QW-1:0]             cnt20;
    logic [QW-1:0]             cnt13;
    logic [QW-1:0]             nsum20;
    logic                      qual_next;
    boh_pkg::vote_ctl_t        vote_ctl;
    logic [VOTE_W-1:0]         tally_next [boh_pkg::NUM_BINS];
    logic                      v4_reg;
    logic [boh_pkg::BIN_W-1:0] peak4_reg;
    logic [CNT_W-1:0]          nsum4_reg;
    logic [CNT_W-1:0]          cnt4_reg;
    logic                      qual4_reg;
    logic                      lf4_reg;
    logic [VOTE_W-1:0]         tally4_reg [boh_pkg::NUM_BINS];

    // stage 5: output register
    logic [boh_pkg::BIN_W-1:0] fdir_next;
    logic                      v5_reg;
    logic [boh_pkg::BIN_W-1:0] peak5_reg;
    logic [CNT_W-1:0]          nsum5_reg;
    logic [CNT_W-1:0]          cnt5_reg;
    logic                      qual5_reg;
    logic [boh_pkg::BIN_W-1:0] fdir5_reg;
    logic                      fdone5_reg;

    // ------------------------------------------------------------------
    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= boh_pkg::THRESHOLD_RESET;
            bp_reg  <= boh_pkg::BLOCK_PIXELS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                boh_pkg::CFG_THRESHOLD:    thr_reg <= cfg_data[boh_pkg::THR_W-1:0];
                boh_pkg::CFG_BLOCK_PIXELS: bp_reg  <= cfg_data[boh_pkg::BP_W-1:0];
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control; pixels that do not end a block retire at stage 1
    assign rdy5 = !v5_reg || !out_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || !lb1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign adv1 = v1_reg && rdy1;
    assign adv3 = v3_reg && rdy4;

    assign in_stall = !rdy0;

    // ------------------------------------------------------------------
    // stage 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (rdy0)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy0)
        begin
            gx0_reg <= grad_x;
            gy0_reg <= grad_y;
            lb0_reg <= last_in_block;
            lf0_reg <= last_in_frame;
        end
    end

    // ------------------------------------------------------------------
    // stage 1
    boh_classify u_classify (
        .grad_x (gx0_reg),
        .grad_y (gy0_reg),
        .mag_sq (mag_next),
        .bin_en (bin_en_next),
        .bin    (bin_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (rdy1)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v0_reg && rdy1)
        begin
            mag1_reg    <= mag_next;
            bin_en1_reg <= bin_en_next;
            bin1_reg    <= bin_next;
            lb1_reg     <= lb0_reg;
            lf1_reg     <= lf0_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2
    assign acc_ctl.upd    = adv1 && (mag1_reg > boh_pkg::MAG_W'(thr_reg));
    assign acc_ctl.bin_en = bin_en1_reg;
    assign acc_ctl.bin    = bin1_reg;
    assign acc_ctl.clear  = adv1 && lb1_reg;

    boh_bin_accum #(
        .CNT_W   (CNT_W),
        .MAX_CNT (MAX_BLOCK_PIXELS)
    ) u_bin_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (acc_ctl),
        .bins_next (bins_next),
        .cnt_next  (cnt_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (rdy2)
            v2_reg <= adv1 && lb1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && lb1_reg)
        begin
            bins2_reg <= bins_next;
            cnt2_reg  <= cnt_next;
            lf2_reg   <= lf1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3
    boh_argmax8 #(
        .WIDTH (CNT_W)
    ) u_block_peak (
        .vals (bins2_reg),
        .idx  (peak_next)
    );

    always_comb
    begin
        nsum_wide = SUM_W'(bins2_reg[peak_next - 1'b1]) + SUM_W'(bins2_reg[peak_next])
                  + SUM_W'(bins2_reg[peak_next + 1'b1]);
        nsum_next = (nsum_wide > SUM_CAP) ? CNT_W'(MAX_BLOCK_PIXELS)
                                          : nsum_wide[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (rdy3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && rdy3)
        begin
            peak3_reg <= peak_next;
            nsum3_reg <= nsum_next;
            cnt3_reg  <= cnt2_reg;
            lf3_reg   <= lf2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: count*20 > block_pixels and sum*20 >= count*13
    always_comb
    begin
        cnt20     = (QW'(cnt3_reg) << 4) + (QW'(cnt3_reg) << 2);
        cnt13     = (QW'(cnt3_reg) << 3) + (QW'(cnt3_reg) << 2) + QW'(cnt3_reg);
        nsum20    = (QW'(nsum3_reg) << 4) + (QW'(nsum3_reg) << 2);
        qual_next = (cnt20 > QW'(bp_reg)) && (nsum20 >= cnt13);
    end

    assign vote_ctl.vote  = adv3 && qual_next;
    assign vote_ctl.bin   = peak3_reg;
    assign vote_ctl.clear = adv3 && lf3_reg;

    boh_vote_tally #(
        .VOTE_W    (VOTE_W),
        .MAX_VOTES (MAX_BLOCKS)
    ) u_vote_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (vote_ctl),
        .tally_next (tally_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (rdy4)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            peak4_reg  <= peak3_reg;
            nsum4_reg  <= nsum3_reg;
            cnt4_reg   <= cnt3_reg;
            qual4_reg  <= qual_next;
            lf4_reg    <= lf3_reg;
            tally4_reg <= tally_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5
    boh_argmax8 #(
        .WIDTH (VOTE_W)
    ) u_frame_peak (
        .vals (tally4_reg),
        .idx  (fdir_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (rdy5)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg && rdy5)
        begin
            peak5_reg  <= peak4_reg;
            nsum5_reg  <= nsum4_reg;
            cnt5_reg   <= cnt4_reg;
            qual5_reg  <= qual4_reg;
            fdir5_reg  <= lf4_reg ? fdir_next : boh_pkg::BIN_W'(0);
            fdone5_reg <= lf4_reg;
        end
    end

    assign out_valid       = v5_reg;
    assign block_direction = peak5_reg;
    assign neighbor_sum    = nsum5_reg;
    assign valid_count     = cnt5_reg;
    assign block_qualified = qual5_reg;
    assign frame_direction = fdir5_reg;
    assign frame_done      = fdone5_reg;

    // ------------------------------------------------------------------
    // checks
    `BOH_ASSERT_IMPLY(a_sum_within_count, out_valid, neighbor_sum <= valid_count)
    `BOH_ASSERT_IMPLY(a_qual_needs_pixels, out_valid && block_qualified, valid_count != '0)
    `BOH_ASSERT_IMPLY(a_frame_dir_idle, out_valid && !frame_done, frame_direction == '0)
    `BOH_ASSERT_NEXT(a_block_end_moves, adv1 && lb1_reg, v2_reg)

endmodule

@@ tb/sv/boh_result_check.sv @@
// Result checker for the block orientation histogram: predicts and compares block results.
`timescale 1ns / 100ps

module boh_result_check #(
    parameter int MAX_BLOCK_PIXELS = 8192,
    parameter int MAX_BLOCKS       = 1024,
    parameter int CNT_W            = $clog2(MAX_BLOCK_PIXELS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [boh_pkg::GRAD_W-1:0]   grad_x,
    input  logic signed [boh_pkg::GRAD_W-1:0]   grad_y,
    input  logic                                last_in_block,
    input  logic                                last_in_frame,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [boh_pkg::BIN_W-1:0]           block_direction,
    input  logic [CNT_W-1:0]                    neighbor_sum,
    input  logic [CNT_W-1:0]                    valid_count,
    input  logic                                block_qualified,
    input  logic [boh_pkg::BIN_W-1:0]           frame_direction,
    input  logic                                frame_done,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [boh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [boh_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  mismatches,
    output int                                  pending
);

    localparam int     NUM_BINS    = boh_pkg::NUM_BINS;
    localparam int     BIN_W       = boh_pkg::BIN_W;
    localparam int     NO_SECTOR   = boh_pkg::NUM_BINS;
    localparam longint TAN_LO      = boh_pkg::TAN_1_8;
    localparam longint TAN_MID     = 65536;
    localparam longint TAN_HI      = boh_pkg::TAN_3_8;
    localparam int     SCORE_NUM   = 13;
    localparam int     SCORE_DEN   = 20;
    localparam int     PRINT_LIMIT = 100;

    typedef struct packed {
        logic [BIN_W-1:0] direction;
        logic [CNT_W-1:0] nsum;
        logic [CNT_W-1:0] count;
        logic             qualified;
        logic [BIN_W-1:0] frame_dir;
        logic             done;
    } block_result_t;

    block_result_t predicted_blocks[$];
    int            bin_count[NUM_BINS];
    int            vote_count[NUM_BINS];
    int            strong_pixels;
    longint        threshold_sq;
    longint        pixels_per_block;

    // Orientation folded into [0, pi); NO_SECTOR for an angle of exactly pi.
    function automatic int sector(input int gx, input int gy);
        longint x;
        longint y;
        longint yy;
        x = gx;
        y = gy;
        if (y < 0)
        begin
            x = -x;
            y = -y;
        end
        if (y == 0)
            return (x < 0) ? NO_SECTOR : 0;
        yy = y * TAN_MID;
        if (x > 0)
        begin
            if (yy < x * TAN_LO) return 0;
            if (yy < x * TAN_MID) return 1;
            if (yy < x * TAN_HI) return 2;
            return 3;
        end
        if (x == 0)
            return int'(boh_pkg::BIN_VERTICAL);
        x = -x;
        if (yy > x * TAN_HI) return 4;
        if (yy > x * TAN_MID) return 5;
        if (yy > x * TAN_LO) return 6;
        return 7;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (got !== want)
        begin
            if (mismatches < PRINT_LIMIT)
                $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : observe
        int            gx;
        int            gy;
        int            s;
        int            peak;
        int            best;
        int            nsum_i;
        longint        mag2;
        block_result_t want;
        if (!rst_n)
        begin
            predicted_blocks.delete();
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bin_count[i]  = 0;
                vote_count[i] = 0;
            end
            strong_pixels    = 0;
            threshold_sq     = boh_pkg::THRESHOLD_RESET;
            pixels_per_block = boh_pkg::BLOCK_PIXELS_RESET;
            mismatches       = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == boh_pkg::CFG_THRESHOLD)
                    threshold_sq = cfg_data[boh_pkg::THR_W-1:0];
                else if (cfg_index == boh_pkg::CFG_BLOCK_PIXELS)
                    pixels_per_block = cfg_data[boh_pkg::BP_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                if (predicted_blocks.size() == 0)
                    report_mismatch("result transfer with no block end pending", 1, 0);
                else
                begin
                    want = predicted_blocks.pop_front();
                    report_mismatch("block_direction", block_direction, want.direction);
                    report_mismatch("neighbor_sum", neighbor_sum, want.nsum);
                    report_mismatch("valid_count", valid_count, want.count);
                    report_mismatch("block_qualified", block_qualified, want.qualified);
                    report_mismatch("frame_direction", frame_direction, want.frame_dir);
                    report_mismatch("frame_done", frame_done, want.done);
                end
            end

            if (in_valid && !in_stall)
            begin
                gx   = grad_x;
                gy   = grad_y;
                mag2 = longint'(gx) * gx + longint'(gy) * gy;
                if (mag2 > threshold_sq)
                begin
                    s = sector(gx, gy);
                    if (strong_pixels < MAX_BLOCK_PIXELS)
                        strong_pixels++;
                    if (s != NO_SECTOR && bin_count[s] < MAX_BLOCK_PIXELS)
                        bin_count[s]++;
                end
                if (last_in_block)
                begin
                    peak = 0;
                    best = 0;
                    for (int i = 0; i < NUM_BINS; i++)
                        if (bin_count[i] > best)
                        begin
                            best = bin_count[i];
                            peak = i;
                        end
                    nsum_i = bin_count[(peak + NUM_BINS - 1) % NUM_BINS] + bin_count[peak]
                           + bin_count[(peak + 1) % NUM_BINS];
                    if (nsum_i > MAX_BLOCK_PIXELS)
                        nsum_i = MAX_BLOCK_PIXELS;
                    want.direction = BIN_W'(peak);
                    want.nsum      = CNT_W'(nsum_i);
                    want.count     = CNT_W'(strong_pixels);
                    want.qualified = (longint'(strong_pixels) * SCORE_DEN > pixels_per_block)
                                  && (nsum_i * SCORE_DEN >= strong_pixels * SCORE_NUM);
                    if (want.qualified && vote_count[peak] < MAX_BLOCKS)
                        vote_count[peak]++;
                    want.frame_dir = '0;
                    want.done      = last_in_frame;
                    if (last_in_frame)
                    begin
                        best = 0;
                        for (int i = 0; i < NUM_BINS; i++)
                            if (vote_count[i] > best)
                            begin
                                best           = vote_count[i];
                                want.frame_dir = BIN_W'(i);
                            end
                        for (int i = 0; i < NUM_BINS; i++)
                            vote_count[i] = 0;
                    end
                    predicted_blocks = {predicted_blocks, want};
                    for (int i = 0; i < NUM_BINS; i++)
                        bin_count[i] = 0;
                    strong_pixels = 0;
                end
            end
            pending <= predicted_blocks.size();
        end
    end

endmodule

@@ tb/sv/tb_block_orientation_histogram.sv @@
// Testbench top for the block orientation histogram: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_block_orientation_histogram;

    localparam int MAX_BLOCK_PIXELS = 8192;
    localparam int MAX_BLOCKS       = 1024;
    localparam int CNT_W            = $clog2(MAX_BLOCK_PIXELS + 1);
    localparam int SETTLE_CYCLES    = 12;
    localparam int IDLE_LIMIT       = 2000;
    localparam int PIXELS_PER_PHASE = 90;

    localparam logic [boh_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [boh_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int THRESHOLD_MAX = (1 << boh_pkg::THR_W) - 1;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic signed [boh_pkg::GRAD_W-1:0]    grad_x;
    logic signed [boh_pkg::GRAD_W-1:0]    grad_y;
    logic                                 last_in_block;
    logic                                 last_in_frame;
    logic                                 out_valid;
    logic                                 out_stall;
    logic [boh_pkg::BIN_W-1:0]            block_direction;
    logic [CNT_W-1:0]                     neighbor_sum;
    logic [CNT_W-1:0]                     valid_count;
    logic                                 block_qualified;
    logic [boh_pkg::BIN_W-1:0]            frame_direction;
    logic                                 frame_done;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [boh_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [boh_pkg::CFG_DATA_W-1:0]       cfg_data;
    int                                   mismatches;
    int                                   pending;
    bit                                   calm = 1'b1;

    block_orientation_histogram #(
        .MAX_BLOCK_PIXELS (MAX_BLOCK_PIXELS),
        .MAX_BLOCKS       (MAX_BLOCKS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .grad_x          (grad_x),
        .grad_y          (grad_y),
        .last_in_block   (last_in_block),
        .last_in_frame   (last_in_frame),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .block_direction (block_direction),
        .neighbor_sum    (neighbor_sum),
        .valid_count     (valid_count),
        .block_qualified (block_qualified),
        .frame_direction (frame_direction),
        .frame_done      (frame_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    boh_result_check #(
        .MAX_BLOCK_PIXELS (MAX_BLOCK_PIXELS),
        .MAX_BLOCKS       (MAX_BLOCKS)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .grad_x          (grad_x),
        .grad_y          (grad_y),
        .last_in_block   (last_in_block),
        .last_in_frame   (last_in_frame),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .block_direction (block_direction),
        .neighbor_sum    (neighbor_sum),
        .valid_count     (valid_count),
        .block_qualified (block_qualified),
        .frame_direction (frame_direction),
        .frame_done      (frame_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Gradient of magnitude scale k lying inside the given orientation bin.
    function automatic void aim(input int bin_idx, input int k, output int gx, output int gy);
        unique case (bin_idx)
            0:       {gx, gy} = {int'(100), int'(10)};
            1:       {gx, gy} = {int'(100), int'(60)};
            2:       {gx, gy} = {int'(60), int'(100)};
            3:       {gx, gy} = {int'(10), int'(100)};
            4:       {gx, gy} = {int'(-10), int'(100)};
            5:       {gx, gy} = {int'(-60), int'(100)};
            6:       {gx, gy} = {int'(-100), int'(60)};
            default: {gx, gy} = {int'(-100), int'(10)};
        endcase
        gx = gx * k;
        gy = gy * k;
    endfunction

    initial
    begin : receiver_stall
        int n;
        out_stall <= 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            n = gap_cycles();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_pixel(input int gx, input int gy, input bit block_end, input bit frame_end);
        int n;
        n = gap_cycles();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid      <= 1'b1;
        grad_x        <= gx[boh_pkg::GRAD_W-1:0];
        grad_y        <= gy[boh_pkg::GRAD_W-1:0];
        last_in_block <= block_end;
        last_in_frame <= frame_end;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random_pixel(input int lead, input bit block_end, input bit frame_end);
        int r;
        int k;
        int gx;
        int gy;
        r = $urandom_range(0, 99);
        k = $urandom_range(1, 40);
        if ($urandom_range(0, 1))
            k = -k;
        if (r < 55)
            aim(lead, k, gx, gy);
        else if (r < 65)
            aim($urandom_range(0, 7), k, gx, gy);
        else if (r < 80)
        begin
            gx = int'($urandom_range(0, 8191)) - 4096;
            gy = int'($urandom_range(0, 8191)) - 4096;
        end
        else if (r < 90)
        begin
            gx = int'($urandom_range(0, 6)) - 3;
            gy = int'($urandom_range(0, 6)) - 3;
        end
        else if (r < 95)
        begin
            gx = 0;
            gy = int'($urandom_range(0, 8191)) - 4096;
        end
        else
        begin
            gx = int'($urandom_range(0, 8191)) - 4096;
            gy = 0;
        end
        // stray frame marks away from block ends must be ignored
        send_pixel(gx, gy, block_end,
                   frame_end || (!block_end && $urandom_range(0, 19) == 0));
    endtask

    task automatic run_frames(input int n_pixels);
        int sent;
        int blocks;
        int len;
        int lead;
        sent = 0;
        while (sent < n_pixels)
        begin
            calm   = ($urandom_range(0, 4) == 0);
            blocks = $urandom_range(1, 5);
            for (int b = 0; b < blocks; b++)
            begin
                len  = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40)
                                                    : $urandom_range(1, 10);
                lead = $urandom_range(0, 7);
                for (int p = 0; p < len; p++)
                    send_random_pixel(lead, p == len - 1, (p == len - 1) && (b == blocks - 1));
                sent += len;
            end
        end
        calm = 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [boh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [boh_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int thr, input int bp);
        logic [boh_pkg::CFG_DATA_W-1:0] bp_word;
        bp_word                     = boh_pkg::CFG_DATA_W'($urandom);
        bp_word[boh_pkg::BP_W-1:0]  = bp[boh_pkg::BP_W-1:0];
        settle();
        if ($urandom_range(0, 1))
            write_reg(CFG_SPARE_2, boh_pkg::CFG_DATA_W'($urandom));
        write_reg(boh_pkg::CFG_THRESHOLD, boh_pkg::CFG_DATA_W'(thr));
        write_reg(boh_pkg::CFG_BLOCK_PIXELS, bp_word);
        write_reg(CFG_SPARE_3, boh_pkg::CFG_DATA_W'($urandom));
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        grad_x        <= '0;
        grad_y        <= '0;
        last_in_block <= 1'b0;
        last_in_frame <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        calm = 1'b0;

        // reset register values: threshold 0, 4900 pixels per block
        send_pixel(0, 0, 1'b0, 1'b0);
        send_pixel(-5, 0, 1'b0, 1'b0);
        send_pixel(5, 0, 1'b0, 1'b0);
        send_pixel(0, 7, 1'b0, 1'b0);
        send_pixel(0, -7, 1'b0, 1'b0);
        send_pixel(2, 1, 1'b0, 1'b0);
        send_pixel(1, 1, 1'b0, 1'b0);
        send_pixel(1, 3, 1'b0, 1'b0);
        send_pixel(-1, 2, 1'b0, 1'b0);
        send_pixel(-1, 1, 1'b0, 1'b0);
        send_pixel(-10, 1, 1'b0, 1'b0);
        send_pixel(4095, 1, 1'b0, 1'b1);
        send_pixel(-4096, -4096, 1'b0, 1'b0);
        send_pixel(1, -4096, 1'b0, 1'b0);
        send_pixel(-4096, 0, 1'b1, 1'b0);
        // peak at bin 0 with bin 7 as its lower neighbor
        send_pixel(-10, 1, 1'b0, 1'b0);
        send_pixel(-10, 1, 1'b0, 1'b0);
        send_pixel(5, 0, 1'b0, 1'b0);
        send_pixel(4080, 4080, 1'b0, 1'b0);
        send_pixel(5, 0, 1'b0, 1'b0);
        send_pixel(2, 1, 1'b0, 1'b0);
        send_pixel(-4096, 4095, 1'b1, 1'b1);
        send_pixel(0, 0, 1'b1, 1'b1);

        configure(0, 1);
        run_frames(PIXELS_PER_PHASE);
        configure(THRESHOLD_MAX, MAX_BLOCK_PIXELS);
        run_frames(PIXELS_PER_PHASE);
        configure(10000, 20);
        run_frames(PIXELS_PER_PHASE);
        configure($urandom_range(0, 200000), $urandom_range(1, 60));
        run_frames(PIXELS_PER_PHASE);
        configure(400, 0);
        run_frames(PIXELS_PER_PHASE);
        configure(1000000, 16383);
        run_frames(PIXELS_PER_PHASE);

        settle();
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
